### design/uxe_pkg.sv
package uxe_pkg;

    // Field widths fixed by the item format
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;                 // code point bits
    localparam int DIG_N  = 7;                  // decimal digits of a 21-bit value
    localparam int BCD_W  = 4 * DIG_N;
    localparam int CNT_W  = $clog2(CP_W + 1);
    localparam int NDIG_W = $clog2(DIG_N + 1);

    // Characters
    localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;  // &
    localparam logic [BYTE_W-1:0] CH_LT   = 8'h3C;  // <
    localparam logic [BYTE_W-1:0] CH_GT   = 8'h3E;  // >
    localparam logic [BYTE_W-1:0] CH_QUOT = 8'h22;  // "
    localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;  // #
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;  // ;
    localparam logic [BYTE_W-1:0] CH_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_G    = 8'h67;
    localparam logic [BYTE_W-1:0] CH_L    = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_M    = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_O    = 8'h6F;
    localparam logic [BYTE_W-1:0] CH_P    = 8'h70;
    localparam logic [BYTE_W-1:0] CH_Q    = 8'h71;
    localparam logic [BYTE_W-1:0] CH_T    = 8'h74;
    localparam logic [BYTE_W-1:0] CH_U    = 8'h75;
    localparam logic [3:0]        DIGIT_HI = 4'h3;  // upper nibble of '0'..'9'

    // Text sequences for escaped ASCII
    localparam logic [2:0] K_PLAIN = 3'd0;
    localparam logic [2:0] K_AMP   = 3'd1;
    localparam logic [2:0] K_LT    = 3'd2;
    localparam logic [2:0] K_GT    = 3'd3;
    localparam logic [2:0] K_QUOT  = 3'd4;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } t_out_item;

    // Index of the final byte of each escape sequence
    function automatic logic [2:0] text_last(input logic [2:0] kind);
        logic [2:0] r;
        case (kind)
            K_AMP:   r = 3'd4;
            K_LT:    r = 3'd3;
            K_GT:    r = 3'd3;
            K_QUOT:  r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Byte idx of an escape sequence; the leading '&' and trailing ';' are shared
    function automatic logic [BYTE_W-1:0] text_char(input logic [2:0] kind,
                                                    input logic [2:0] idx);
        logic [BYTE_W-1:0] r;
        r = CH_SEMI;
        if (idx == 3'd0) begin
            r = CH_AMP;
        end else begin
            case (kind)
                K_AMP: begin
                    case (idx)
                        3'd1:    r = CH_A;
                        3'd2:    r = CH_M;
                        3'd3:    r = CH_P;
                        default: r = CH_SEMI;
                    endcase
                end
                K_LT: begin
                    case (idx)
                        3'd1:    r = CH_L;
                        3'd2:    r = CH_T;
                        default: r = CH_SEMI;
                    endcase
                end
                K_GT: begin
                    case (idx)
                        3'd1:    r = CH_G;
                        3'd2:    r = CH_T;
                        default: r = CH_SEMI;
                    endcase
                end
                K_QUOT: begin
                    case (idx)
                        3'd1:    r = CH_Q;
                        3'd2:    r = CH_U;
                        3'd3:    r = CH_O;
                        3'd4:    r = CH_T;
                        default: r = CH_SEMI;
                    endcase
                end
                default: r = CH_SEMI;
            endcase
        end
        return r;
    endfunction

endpackage

### design/utf8_xml_escaper.sv
// UTF-8 to XML-safe text escaper.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one byte, or an end-of-string
// marker, per transfer. A zero byte also ends the string and flushes any pending
// multi-byte sequence. Output channel (o_out_valid / i_out_stall / o_out_data): one
// escaped byte per transfer; last_of_run marks the final byte caused by an input.
//
// The block handles one input at a time; o_in_stall is high while it works.
// Plain ASCII: the input byte is held in the text state, then loaded into the output
// register. Escaped & < > " become a named entity of 4 to 6 bytes. A completed UTF-8
// character runs a bit-serial binary-to-BCD converter, drops up to 6 leading zero
// digits one per cycle, then emits &#N; one byte per cycle while the receiver does
// not stall (3 + digit count bytes). Fewer digits mean more trimming. Lead and
// continuation bytes that finish nothing are taken without leaving the idle state.
//
// Output bytes sit in a single output register; while the receiver stalls the
// register holds and emission pauses. Synchronous reset clears the pending
// sequence and drops any output not yet taken.
module utf8_xml_escaper
    import uxe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEXT = 3'd1;   // emit plain byte or named escape
    localparam logic [2:0] S_CONV = 3'd2;   // double-dabble, one bit per cycle
    localparam logic [2:0] S_TRIM = 3'd3;   // drop leading zero digits
    localparam logic [2:0] S_NUM  = 3'd4;   // emit &#N;

    localparam logic [1:0] PH_AMP  = 2'd0;
    localparam logic [1:0] PH_HASH = 2'd1;
    localparam logic [1:0] PH_DIG  = 2'd2;
    localparam logic [1:0] PH_SEMI = 2'd3;

    logic [2:0]        r_state,     n_state;
    logic [1:0]        r_cont_left, n_cont_left;
    logic [CP_W-1:0]   r_cp,        n_cp;
    logic [BCD_W-1:0]  r_bcd,       n_bcd;
    logic [CNT_W-1:0]  r_cnt,       n_cnt;
    logic [NDIG_W-1:0] r_ndig,      n_ndig;
    logic [2:0]        r_kind,      n_kind;
    logic [BYTE_W-1:0] r_char,      n_char;
    logic [2:0]        r_idx,       n_idx;
    logic [1:0]        r_phase,     n_phase;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    logic              in_xfer;
    logic              room;
    logic              emit;
    t_out_item         emit_item;
    logic [BYTE_W-1:0] b;
    logic [BCD_W-1:0]  bcd_adj;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign room        = !r_out_valid || !i_out_stall;
    assign b           = i_in_data.in_byte;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < DIG_N; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cont_left = r_cont_left;
        n_cp        = r_cp;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_ndig      = r_ndig;
        n_kind      = r_kind;
        n_char      = r_char;
        n_idx       = r_idx;
        n_phase     = r_phase;
        emit        = 1'b0;
        emit_item   = '{out_byte: r_char, last_of_run: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.action || b == '0) begin
                        // End of string: flush pending sequence
                        n_cont_left = '0;
                        n_cp        = '0;
                    end else if (b[7:6] == 2'b10) begin
                        if (r_cont_left != 2'd0) begin
                            n_cp        = {r_cp[CP_W-7:0], b[5:0]};
                            n_cont_left = r_cont_left - 2'd1;
                            if (r_cont_left == 2'd1) begin
                                // Sequence complete; r_cp shifts out to zero
                                n_bcd   = '0;
                                n_cnt   = CNT_W'(CP_W);
                                n_state = S_CONV;
                            end
                        end
                    end else begin
                        n_cont_left = '0;
                        n_cp        = '0;
                        n_idx       = '0;
                        n_char      = b;
                        if (!b[7]) begin
                            case (b)
                                CH_AMP:  n_kind = K_AMP;
                                CH_LT:   n_kind = K_LT;
                                CH_GT:   n_kind = K_GT;
                                CH_QUOT: n_kind = K_QUOT;
                                default: n_kind = K_PLAIN;
                            endcase
                            n_state = S_TEXT;
                        end else if (b[7:5] == 3'b110) begin
                            n_cont_left = 2'd1;
                            n_cp        = CP_W'(b[4:0]);
                        end else if (b[7:4] == 4'b1110) begin
                            n_cont_left = 2'd2;
                            n_cp        = CP_W'(b[3:0]);
                        end else if (b[7:3] == 5'b11110) begin
                            n_cont_left = 2'd3;
                            n_cp        = CP_W'(b[2:0]);
                        end
                        // invalid lead: drop (stray continuations are dropped above)
                    end
                end
            end

            S_TEXT: begin
                if (room) begin
                    emit = 1'b1;
                    if (r_kind == K_PLAIN) begin
                        emit_item = '{out_byte: r_char, last_of_run: 1'b1};
                        n_state   = S_IDLE;
                    end else begin
                        emit_item.out_byte    = text_char(r_kind, r_idx);
                        emit_item.last_of_run = (r_idx == text_last(r_kind));
                        n_idx                 = r_idx + 3'd1;
                        if (r_idx == text_last(r_kind)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            S_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_cp[CP_W-1]};
                n_cp  = {r_cp[CP_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_ndig  = NDIG_W'(DIG_N);
                    n_state = S_TRIM;
                end
            end

            S_TRIM: begin
                if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_ndig > NDIG_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - NDIG_W'(1);
                end else begin
                    n_phase = PH_AMP;
                    n_state = S_NUM;
                end
            end

            S_NUM: begin
                if (room) begin
                    emit = 1'b1;
                    case (r_phase)
                        PH_AMP: begin
                            emit_item.out_byte = CH_AMP;
                            n_phase            = PH_HASH;
                        end
                        PH_HASH: begin
                            emit_item.out_byte = CH_HASH;
                            n_phase            = PH_DIG;
                        end
                        PH_DIG: begin
                            emit_item.out_byte = {DIGIT_HI, r_bcd[BCD_W-1 -: 4]};
                            n_bcd              = {r_bcd[BCD_W-5:0], 4'd0};
                            n_ndig             = r_ndig - NDIG_W'(1);
                            if (r_ndig == NDIG_W'(1)) begin
                                n_phase = PH_SEMI;
                            end
                        end
                        default: begin
                            emit_item = '{out_byte: CH_SEMI, last_of_run: 1'b1};
                            n_state   = S_IDLE;
                        end
                    endcase
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Output register: load on emit, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = emit_item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cont_left <= '0;
            r_cp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cont_left <= n_cont_left;
            r_cp        <= n_cp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_ndig  <= n_ndig;
        r_kind  <= n_kind;
        r_char  <= n_char;
        r_idx   <= n_idx;
        r_phase <= n_phase;
        r_out   <= n_out;
    end

    // No sequence is pending while the block is busy with an output
    a_busy_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cont_left == 2'd0))
        else $error("pending sequence while busy");

    // Conversion shifts the whole code point out, leaving it cleared
    a_conv_clears_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_cnt == CNT_W'(1)) |=> (r_cp == '0))
        else $error("code point not cleared after conversion");

    // At least one digit is always left to emit
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM || (r_state == S_NUM && r_phase == PH_DIG))
            |-> (r_ndig != '0))
        else $error("digit count ran out");

endmodule
